// ===== hw/rtl/rgb_to_chromaticity_rgi_top_defines.svh =====
// assertion macros for the rgb chromaticity block
// depends on: clk and rst_n in the scope of each use
`ifndef RGB_TO_CHROMATICITY_RGI_TOP_DEFINES_SVH
`define RGB_TO_CHROMATICITY_RGI_TOP_DEFINES_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define RGBCHR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds in a cycle, consequent holds in the next one
`define RGBCHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rgbchr_pkg.sv =====
// widths, pipeline constants and reciprocal for the rgb chromaticity block
// no dependencies
package rgbchr_pkg;

  localparam int CHAN_W      = 8;                  // one color component
  localparam int SUM_W       = 10;                 // sum of three components, up to 765
  localparam int PROD_W      = 16;                 // component times full scale
  localparam int FULL_SCALE  = 255;

  // restoring divider, two quotient bits per stage
  localparam int DIV_BITS    = 2;
  localparam int DIV_STAGES  = CHAN_W / DIV_BITS;
  localparam int QIDX_W      = $clog2(CHAN_W);     // index of one quotient bit

  // sum / 3 as (sum * 683) >> 11, exact for sums up to 765
  localparam int RECIP3       = 683;
  localparam int RECIP3_W     = 10;
  localparam int RECIP3_SHIFT = 11;
  localparam int IPROD_W      = SUM_W + RECIP3_W;

  // accept register, divider stages, output register
  localparam int PIPE_LAT    = DIV_STAGES + 2;

endpackage

// ===== hw/rtl/rgbchr_div.sv =====
// pipelined restoring divider: 16-bit dividend by 10-bit divisor, 8-bit quotient
// depends on: rgbchr_pkg; quotient valid only when dividend < 256 * divisor
module rgbchr_div (
  input  logic                             clk,
  input  logic [rgbchr_pkg::PROD_W-1:0]    dividend,
  input  logic [rgbchr_pkg::SUM_W-1:0]     divisor,
  output logic [rgbchr_pkg::CHAN_W-1:0]    quotient
);

  logic [rgbchr_pkg::PROD_W-1:0] rem_in   [rgbchr_pkg::DIV_STAGES];
  logic [rgbchr_pkg::SUM_W-1:0]  dvs_in   [rgbchr_pkg::DIV_STAGES];
  logic [rgbchr_pkg::CHAN_W-1:0] quo_in   [rgbchr_pkg::DIV_STAGES];
  logic [rgbchr_pkg::PROD_W-1:0] rem_nxt  [rgbchr_pkg::DIV_STAGES];
  logic [rgbchr_pkg::CHAN_W-1:0] quo_nxt  [rgbchr_pkg::DIV_STAGES];
  logic [rgbchr_pkg::PROD_W-1:0] rem_r    [rgbchr_pkg::DIV_STAGES];
  logic [rgbchr_pkg::SUM_W-1:0]  dvs_r    [rgbchr_pkg::DIV_STAGES];
  logic [rgbchr_pkg::CHAN_W-1:0] quo_r    [rgbchr_pkg::DIV_STAGES];

  for (genvar k = 0; k < rgbchr_pkg::DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign rem_in[k] = dividend;
      assign dvs_in[k] = divisor;
      assign quo_in[k] = '0;
    end else begin : g_rest
      assign rem_in[k] = rem_r[k-1];
      assign dvs_in[k] = dvs_r[k-1];
      assign quo_in[k] = quo_r[k-1];
    end

    // two trial subtractions, most significant quotient bit first
    always_comb begin
      logic [rgbchr_pkg::PROD_W+1:0] shf;
      logic [rgbchr_pkg::PROD_W-1:0] rem;
      logic [rgbchr_pkg::CHAN_W-1:0] quo;
      logic [rgbchr_pkg::QIDX_W-1:0] bidx;
      rem = rem_in[k];
      quo = quo_in[k];
      for (int j = 0; j < rgbchr_pkg::DIV_BITS; j++) begin
        bidx = rgbchr_pkg::QIDX_W'(rgbchr_pkg::CHAN_W - 1
                                   - k * rgbchr_pkg::DIV_BITS - j);
        shf  = {{(rgbchr_pkg::PROD_W + 2 - rgbchr_pkg::SUM_W){1'b0}}, dvs_in[k]} << bidx;
        if ({2'b00, rem} >= shf) begin
          rem       = rem - shf[rgbchr_pkg::PROD_W-1:0];
          quo[bidx] = 1'b1;
        end
      end
      rem_nxt[k] = rem;
      quo_nxt[k] = quo;
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt[k];
      dvs_r[k] <= dvs_in[k];
      quo_r[k] <= quo_nxt[k];
    end
  end

  assign quotient = quo_r[rgbchr_pkg::DIV_STAGES-1];

endmodule

// ===== hw/rtl/rgb_to_chromaticity_rgi_top.sv =====
// top level of the rgb chromaticity and intensity block
// depends on: rgbchr_pkg, rgbchr_div, rgb_to_chromaticity_rgi_top_defines.svh
//
// usage
//   input: drive in_red_in, in_green_in, in_blue_in and raise start; the pixel
//   is taken at a clock edge with start high and busy low. busy is low at all
//   times out of reset, so one pixel transfer can happen on every clock.
//   output: out_valid is high for exactly one cycle per pixel, with
//   out_chroma_red = red*255/sum, out_chroma_green = green*255/sum and
//   out_intensity_out = sum/3, all truncated, all zero for a black pixel.
//   order: results leave in input order, through the accept register, the
//   divider stages and the output register.
//   throughput: one pixel per cycle; the rate is set by the divider, which is
//   cut into four stages of two quotient bits each, one per pipeline stage.
//   reset: synchronous, active low; clears every valid bit so no stray
//   strobe appears, and busy stays high while reset is held.
//   the receiver cannot stall: results stream out on the strobe and must be
//   taken in the cycle they appear.
`include "rgb_to_chromaticity_rgi_top_defines.svh"

module rgb_to_chromaticity_rgi_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rgbchr_pkg::CHAN_W-1:0] in_red_in,
  input  logic [rgbchr_pkg::CHAN_W-1:0] in_green_in,
  input  logic [rgbchr_pkg::CHAN_W-1:0] in_blue_in,
  output logic                          out_valid,
  output logic [rgbchr_pkg::CHAN_W-1:0] out_chroma_red,
  output logic [rgbchr_pkg::CHAN_W-1:0] out_chroma_green,
  output logic [rgbchr_pkg::CHAN_W-1:0] out_intensity_out
);

  localparam int DS = rgbchr_pkg::DIV_STAGES;

  logic in_xfer;

  // stage 0: sum and scaled dividends
  logic [rgbchr_pkg::SUM_W-1:0]  sum_nxt;
  logic [rgbchr_pkg::SUM_W-1:0]  sum_r;
  logic [rgbchr_pkg::PROD_W-1:0] dvd_red_nxt;
  logic [rgbchr_pkg::PROD_W-1:0] dvd_grn_nxt;
  logic [rgbchr_pkg::PROD_W-1:0] dvd_red_r;
  logic [rgbchr_pkg::PROD_W-1:0] dvd_grn_r;

  // valid and black-pixel flag travel with the data, stages 0 to DS
  logic [DS:0] vld_r;
  logic [DS:0] blk_r;

  // intensity: product in stage 1, quotient in stages 2 to DS
  logic [rgbchr_pkg::IPROD_W-1:0] iprod_nxt;
  logic [rgbchr_pkg::IPROD_W-1:0] iprod_r;
  logic [rgbchr_pkg::CHAN_W-1:0]  int_r [DS-1];

  logic [rgbchr_pkg::CHAN_W-1:0] quo_red;
  logic [rgbchr_pkg::CHAN_W-1:0] quo_grn;

  // output register
  logic                          out_valid_r;
  logic [rgbchr_pkg::CHAN_W-1:0] out_red_r;
  logic [rgbchr_pkg::CHAN_W-1:0] out_grn_r;
  logic [rgbchr_pkg::CHAN_W-1:0] out_int_r;

  // pipeline never stalls, so only reset holds off input
  assign busy    = !rst_n;
  assign in_xfer = start && !busy;

  // x * 255 as (x << 8) - x
  assign sum_nxt = {2'b00, in_red_in} + {2'b00, in_green_in} + {2'b00, in_blue_in};
  assign dvd_red_nxt = {in_red_in, 8'h00} - {8'h00, in_red_in};
  assign dvd_grn_nxt = {in_green_in, 8'h00} - {8'h00, in_green_in};

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    dvd_red_r <= dvd_red_nxt;
    dvd_grn_r <= dvd_grn_nxt;
    blk_r[0]  <= (sum_nxt == '0);
    for (int s = 1; s <= DS; s++) begin
      blk_r[s] <= blk_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DS-1:0], in_xfer};
    end
  end

  // divisions by the component sum
  rgbchr_div u_div_red (
    .clk      (clk),
    .dividend (dvd_red_r),
    .divisor  (sum_r),
    .quotient (quo_red)
  );

  rgbchr_div u_div_grn (
    .clk      (clk),
    .dividend (dvd_grn_r),
    .divisor  (sum_r),
    .quotient (quo_grn)
  );

  // intensity by reciprocal multiply, delayed to line up with the dividers
  assign iprod_nxt = {{rgbchr_pkg::RECIP3_W{1'b0}}, sum_r}
                   * rgbchr_pkg::IPROD_W'(rgbchr_pkg::RECIP3);

  always_ff @(posedge clk) begin
    iprod_r  <= iprod_nxt;
    int_r[0] <= iprod_r[rgbchr_pkg::RECIP3_SHIFT +: rgbchr_pkg::CHAN_W];
    for (int s = 1; s < DS - 1; s++) begin
      int_r[s] <= int_r[s-1];
    end
  end

  // black pixel forces zero chromaticity, the divider would give all ones
  always_ff @(posedge clk) begin
    out_red_r <= blk_r[DS] ? '0 : quo_red;
    out_grn_r <= blk_r[DS] ? '0 : quo_grn;
    out_int_r <= int_r[DS-2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[DS];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chroma_red    = out_red_r;
  assign out_chroma_green  = out_grn_r;
  assign out_intensity_out = out_int_r;

  // every input transfer yields one strobe a fixed latency later
  // checked once a full pipeline depth of history lies outside reset
  `RGBCHR_ASSERT_SAME(a_latency, $past(rst_n, rgbchr_pkg::PIPE_LAT), out_valid == $past(in_xfer, rgbchr_pkg::PIPE_LAT), "result strobe does not match input transfer")

  // red and green shares never add up past full scale
  `RGBCHR_ASSERT_SAME(a_chroma_sum, out_valid, ({1'b0, out_chroma_red} + {1'b0, out_chroma_green}) <= (rgbchr_pkg::CHAN_W + 1)'(rgbchr_pkg::FULL_SCALE), "chromaticity sum above full scale")

  // pure red pixel leaves no green share
  `RGBCHR_ASSERT_SAME(a_pure_red, out_valid && (out_chroma_red == rgbchr_pkg::CHAN_W'(rgbchr_pkg::FULL_SCALE)), out_chroma_green == '0, "green share on a pure red pixel")

endmodule

// ===== bench/rgb_to_chromaticity_rgi_top_tb.sv =====
// self-checking bench for rgb_to_chromaticity_rgi_top: directed pixel table, then random pixels
// depends on: rgbchr_pkg, rgb_to_chromaticity_rgi_top and its submodules
module rgb_to_chromaticity_rgi_top_tb;

  // one pixel and one chromaticity result, at the block's channel width
  typedef struct packed {
    logic [rgbchr_pkg::CHAN_W-1:0] red;
    logic [rgbchr_pkg::CHAN_W-1:0] green;
    logic [rgbchr_pkg::CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [rgbchr_pkg::CHAN_W-1:0] chroma_red;
    logic [rgbchr_pkg::CHAN_W-1:0] chroma_green;
    logic [rgbchr_pkg::CHAN_W-1:0] intensity;
  } chroma_t;

  // a stimulus row: pixel, whether the result is typed in, and that result
  typedef struct packed {
    logic    typed;
    pixel_t  pix;
    chroma_t res;
  } pixel_row_t;

  localparam int NUM_DIRECTED = 23;
  localparam int NUM_RANDOM   = 1150;
  localparam int CYCLE_LIMIT  = 200000;

  // directed rows; typed results are the extremes and the black pixel,
  // the rest go through the predictor
  localparam pixel_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    {1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},   // black pixel
    {1'b1, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd85},
    {1'b1, 8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd85},
    {1'b1, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd85},
    {1'b1, 8'd255, 8'd255, 8'd255, 8'd85,  8'd85,  8'd255}, // largest sum
    {1'b1, 8'd1,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0},
    {1'b1, 8'd0,   8'd1,   8'd0,   8'd0,   8'd255, 8'd0},
    {1'b1, 8'd0,   8'd0,   8'd1,   8'd0,   8'd0,   8'd0},
    {1'b1, 8'd1,   8'd1,   8'd1,   8'd85,  8'd85,  8'd1},
    {1'b1, 8'd255, 8'd255, 8'd0,   8'd127, 8'd127, 8'd170},
    {1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},   // black again, back to back
    {1'b0, 8'd1,   8'd254, 8'd0,   24'd0},
    {1'b0, 8'd128, 8'd64,  8'd32,  24'd0},
    {1'b0, 8'd200, 8'd100, 8'd3,   24'd0},
    {1'b0, 8'h55,  8'hAA,  8'h0F,  24'd0},
    {1'b0, 8'hAA,  8'h55,  8'hF0,  24'd0},
    {1'b0, 8'd254, 8'd1,   8'd255, 24'd0},
    {1'b0, 8'd2,   8'd0,   8'd1,   24'd0},
    {1'b0, 8'd0,   8'd2,   8'd1,   24'd0},
    {1'b0, 8'd100, 8'd0,   8'd155, 24'd0},
    {1'b0, 8'd127, 8'd128, 8'd0,   24'd0},
    {1'b0, 8'd255, 8'd0,   8'd255, 24'd0},
    {1'b0, 8'd0,   8'd255, 8'd255, 24'd0}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [rgbchr_pkg::CHAN_W-1:0] in_red_in;
  logic [rgbchr_pkg::CHAN_W-1:0] in_green_in;
  logic [rgbchr_pkg::CHAN_W-1:0] in_blue_in;
  logic                          out_valid;
  logic [rgbchr_pkg::CHAN_W-1:0] out_chroma_red;
  logic [rgbchr_pkg::CHAN_W-1:0] out_chroma_green;
  logic [rgbchr_pkg::CHAN_W-1:0] out_intensity_out;

  pixel_row_t pixel_rows [$];   // every pixel to send, in order
  chroma_t    chroma_q   [$];   // results still owed by the block
  int         mismatches;

  rgb_to_chromaticity_rgi_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .out_valid        (out_valid),
    .out_chroma_red   (out_chroma_red),
    .out_chroma_green (out_chroma_green),
    .out_intensity_out(out_intensity_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // chromaticity of one pixel: component times full scale over the sum,
  // sum over three, everything truncated; a black pixel gives all zeros
  function automatic chroma_t chromaticity_of(pixel_t p);
    chroma_t     c;
    int unsigned total;
    total = p.red + p.green + p.blue;
    if (total == 0) begin
      c = '0;
    end else begin
      c.chroma_red   = rgbchr_pkg::CHAN_W'((p.red * 255) / total);
      c.chroma_green = rgbchr_pkg::CHAN_W'((p.green * 255) / total);
      c.intensity    = rgbchr_pkg::CHAN_W'(total / 3);
    end
    return c;
  endfunction

  // random pixels, weighted toward zeros, tiny values, full-scale channels and near-gray pixels
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     mode;
    mode = $urandom_range(0, 9);
    p.red   = rgbchr_pkg::CHAN_W'($urandom);
    p.green = rgbchr_pkg::CHAN_W'($urandom);
    p.blue  = rgbchr_pkg::CHAN_W'($urandom);
    case (mode)
      5: begin
        p.red   = rgbchr_pkg::CHAN_W'($urandom_range(0, 3));
        p.green = rgbchr_pkg::CHAN_W'($urandom_range(0, 3));
        p.blue  = rgbchr_pkg::CHAN_W'($urandom_range(0, 3));
      end
      6: begin
        case ($urandom_range(0, 2))
          0: p.red   = '0;
          1: p.green = '0;
          default: p.blue = '0;
        endcase
      end
      7: begin
        p.red   = $urandom_range(0, 1) ? '1 : '0;
        p.green = $urandom_range(0, 1) ? '1 : '0;
        p.blue  = $urandom_range(0, 1) ? '1 : '0;
      end
      8: begin
        // single lit channel
        p.red   = ($urandom_range(0, 2) == 0) ? p.red : '0;
        p.green = (p.red == 0) ? p.green : '0;
        p.blue  = (p.red == 0 && p.green == 0) ? p.blue : '0;
      end
      9: begin
        // near-gray pixel
        p.green = rgbchr_pkg::CHAN_W'(p.red ^ rgbchr_pkg::CHAN_W'($urandom_range(0, 3)));
        p.blue  = rgbchr_pkg::CHAN_W'(p.red ^ rgbchr_pkg::CHAN_W'($urandom_range(0, 3)));
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic report_field(string name, logic [rgbchr_pkg::CHAN_W-1:0] want,
                              logic [rgbchr_pkg::CHAN_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result checker: every strobe must match the oldest owed result
  always @(posedge clk) begin
    chroma_t want;
    if (rst_n && out_valid) begin
      if (chroma_q.size() == 0) begin
        $error("result with nothing expected: %0d %0d %0d",
               out_chroma_red, out_chroma_green, out_intensity_out);
        mismatches++;
      end else begin
        want = chroma_q.pop_front();
        report_field("chroma_red", want.chroma_red, out_chroma_red);
        report_field("chroma_green", want.chroma_green, out_chroma_green);
        report_field("intensity_out", want.intensity, out_intensity_out);
      end
    end
  end

  // watchdog on the whole run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // sender: bursts of pixel transfers with random gaps between them
  initial begin
    pixel_row_t row;
    int         next_idx;
    int         burst_left;
    int         gap_left;
    pixel_row_t cur;

    mismatches = 0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_red_in   <= '0;
    in_green_in <= '0;
    in_blue_in  <= '0;

    foreach (DIRECTED_ROWS[i]) pixel_rows.push_back(DIRECTED_ROWS[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      row       = '0;
      row.pix   = random_pixel();
      pixel_rows.push_back(row);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    next_idx   = 0;
    burst_left = $urandom_range(1, 40);
    gap_left   = 0;
    cur        = pixel_rows[0];

    while (next_idx < pixel_rows.size()) begin
      @(posedge clk);
      // a transfer happens on this edge when start was up and busy down
      if (start && !busy) begin
        chroma_q.push_back(cur.typed ? cur.res : chromaticity_of(cur.pix));
        next_idx++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          // about a third of the bursts run straight into the next one
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else if (gap_left > 0) begin
        gap_left--;
      end
      // one assignment per signal per edge, so a held start never dips
      if (gap_left == 0 && next_idx < pixel_rows.size()) begin
        cur = pixel_rows[next_idx];
        start       <= 1'b1;
        in_red_in   <= cur.pix.red;
        in_green_in <= cur.pix.green;
        in_blue_in  <= cur.pix.blue;
      end else begin
        start <= 1'b0;
      end
    end

    // drain owed results, then watch a while for stray strobes
    while (chroma_q.size() != 0) @(posedge clk);
    repeat (4 * rgbchr_pkg::PIPE_LAT + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
